// ===== rtl/nptp_pkg.sv =====
// ----------------------------------------------------------------------------
// nptp_pkg
// Shared types, constants and helper functions for the pattern token parser.
// ----------------------------------------------------------------------------
`default_nettype none
package nptp_pkg;

	localparam int MAX_EVENTS_DEF = 256;
	localparam int TOKEN_MAX_DEF  = 63;

	localparam logic [7:0] NOTE_REST = 8'd0;
	localparam logic [7:0] NOTE_K = 8'd250;
	localparam logic [7:0] NOTE_S = 8'd251;
	localparam logic [7:0] NOTE_H = 8'd252;
	localparam logic [7:0] NOTE_O = 8'd253;
	localparam logic [4:0] BAR_STEPS = 5'd16;
	localparam logic [4:0] BAR_SAT   = 5'd17;

	localparam logic [7:0] DUTY_DEF    = 8'd50;
	localparam logic [7:0] GAIN_DEF    = 8'd60;
	localparam logic [7:0] DECAY_DEF   = 8'd0;
	localparam logic [7:0] SUSTAIN_DEF = 8'd100;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EVENTS   = 3'd1;
	localparam logic [2:0] ST_BAR      = 3'd2;
	localparam logic [2:0] ST_HDR_LATE = 3'd3;
	localparam logic [2:0] ST_BAD_VAL  = 3'd4;
	localparam logic [2:0] ST_UNKNOWN  = 3'd5;

	// token phases
	localparam logic [3:0] PH_START    = 4'd0;  // no char yet
	localparam logic [3:0] PH_PREFIX   = 4'd1;  // could still be a header
	localparam logic [3:0] PH_HVAL     = 4'd2;  // header value digits
	localparam logic [3:0] PH_BAR      = 4'd3;  // lone '|'
	localparam logic [3:0] PH_LEN0     = 4'd4;  // after note body, expect ':' or end
	localparam logic [3:0] PH_LENNUM   = 4'd5;  // ':' seen, digits
	localparam logic [3:0] PH_OCT      = 4'd6;  // note letter seen, expect '#' or digit
	localparam logic [3:0] PH_OCTD     = 4'd7;  // '#' seen, expect digit
	localparam logic [3:0] PH_BAD      = 4'd8;  // token is already unknown
	localparam logic [3:0] PH_HBAD     = 4'd9;  // header with bad value

	localparam logic [1:0] HDR_DUTY    = 2'd0;
	localparam logic [1:0] HDR_GAIN    = 2'd1;
	localparam logic [1:0] HDR_DECAY   = 2'd2;
	localparam logic [1:0] HDR_SUSTAIN = 2'd3;

	localparam logic FUNC_CHAR = 1'b0;
	localparam logic FUNC_END  = 1'b1;

	typedef struct packed {
		logic [7:0] duty;
		logic [7:0] gain;
		logic [7:0] decay;
		logic [7:0] sustain;
	} settings_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] note_code;
		logic [7:0] step_len;
		logic [2:0] status;
		settings_t  sets;
		logic [15:0] total_steps;
		logic [8:0] event_count;
	} result_t;

	function automatic logic [3:0] semitone_of(input logic [2:0] idx);
		logic [3:0] r;
		begin
			unique case (idx)
				3'd0: r = 4'd9;
				3'd1: r = 4'd11;
				3'd2: r = 4'd0;
				3'd3: r = 4'd2;
				3'd4: r = 4'd4;
				3'd5: r = 4'd5;
				3'd6: r = 4'd7;
				default: r = 4'd0;
			endcase
			return r;
		end
	endfunction

	// header name character at a given position, 0 past the '='
	function automatic logic [7:0] hdr_char(input logic [1:0] w, input logic [2:0] p);
		logic [63:0] s;
		begin
			unique case (w)
				HDR_DUTY:    s = {"duty=", 24'h0};
				HDR_GAIN:    s = {"gain=", 24'h0};
				HDR_DECAY:   s = {"decay=", 16'h0};
				default:     s = "sustain=";
			endcase
			return s[63 - 8*p -: 8];
		end
	endfunction

	function automatic logic [3:0] hdr_len(input logic [1:0] w);
		logic [3:0] r;
		begin
			unique case (w)
				HDR_DUTY:  r = 4'd5;
				HDR_GAIN:  r = 4'd5;
				HDR_DECAY: r = 4'd6;
				default:   r = 4'd8;
			endcase
			return r;
		end
	endfunction

	function automatic logic [8:0] acc_digit(input logic [8:0] acc, input logic [7:0] c);
		logic [12:0] t;
		begin
			t = {acc, 3'b000} + {2'b00, acc, 1'b0} + {9'd0, c[3:0]} - 13'd0;
			return (t > 13'd256) ? 9'd256 : t[8:0];
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/nptp_stream_if.sv =====
// ----------------------------------------------------------------------------
// nptp_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface nptp_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/nptp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// nptp_out_fifo
// Four-entry result queue; absorbs the up to two results of one beat.
// ----------------------------------------------------------------------------
`default_nettype none
module nptp_out_fifo
	import nptp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push0,
	input  wire result_t din0,
	input  wire logic    push1,
	input  wire result_t din1,
	output logic         space2,
	output logic         valid,
	output result_t      dout,
	input  wire logic    pop
);
	result_t     mem_q [4];
	logic [2:0]  rd_q, wr_q;
	logic [2:0]  cnt;
	logic        do_pop;

	assign cnt    = wr_q - rd_q;
	assign valid  = (cnt != 3'd0);
	assign dout   = mem_q[rd_q[1:0]];
	assign do_pop = pop && valid;
	// room for two from the registered count only, so pop never reaches ready
	assign space2 = (cnt <= 3'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
		end else begin
			rd_q <= rd_q + {2'b00, do_pop};
			wr_q <= wr_q + {2'b00, push0} + {2'b00, push1};
		end
	end

	always_ff @(posedge clk) begin
		if (push0) mem_q[wr_q[1:0]] <= din0;
		if (push1) mem_q[push0 ? wr_q[1:0] + 2'd1 : wr_q[1:0]] <= din1;
	end
endmodule
`default_nettype wire

// ===== rtl/note_pattern_token_parser_core.sv =====
// ----------------------------------------------------------------------------
// note_pattern_token_parser_core
// Streaming parser for one channel of music pattern text.
// ----------------------------------------------------------------------------
// One pattern byte is taken per clock. Tokens are judged incrementally as their
// bytes arrive, so a whitespace byte or an end beat completes a token in that
// same cycle; the produced event and/or final record enter a four-entry result
// queue, whose head drives the output. The input stalls only when that queue
// cannot take two more results, so a steady one beat per cycle is sustained
// whenever the output is drained at one beat per cycle.
`default_nettype none
module note_pattern_token_parser_core
	import nptp_pkg::*;
#(
	parameter int MAX_EVENTS = MAX_EVENTS_DEF,
	parameter int TOKEN_MAX  = TOKEN_MAX_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	nptp_stream_if.sink   in_ch,
	nptp_stream_if.source out_ch
);
	localparam int EW = $clog2(MAX_EVENTS + 1);

	logic [3:0]  phase_q;
	logic [5:0]  chars_q;
	logic [3:0]  pmatch_q;    // bit per header candidate still matching
	logic [1:0]  which_q;
	logic [8:0]  acc_q;
	logic [7:0]  note_q;
	logic [3:0]  oct_q;
	logic [4:0]  bar_q;
	logic [15:0] sum_q;
	logic [EW-1:0] ev_q;
	logic [2:0]  err_q;
	settings_t   set_q;
	logic [3:0]  semi_q;

	logic        func;
	logic [7:0]  c;
	logic        acc_in, space2;
	assign func = in_ch.data[8];
	assign c    = in_ch.data[7:0];
	assign in_ch.ready = space2;
	assign acc_in = in_ch.valid && space2;

	logic is_sp, is_dig;
	assign is_sp  = (c == 8'd32) || (c == 8'd9) || (c == 8'd10) || (c == 8'd13);
	assign is_dig = (c >= 8'd48) && (c <= 8'd57);

	// next-state of token scanner on a kept char
	logic [3:0] nph, npm;
	logic [1:0] nwh;
	logic [8:0] nacc;
	logic [7:0] nnote;
	logic [3:0] noct, nsemi;
	logic [2:0] pos3;
	logic       done;
	logic [3:0] m;

	always_comb begin
		nph = phase_q; npm = pmatch_q; nwh = which_q; nacc = acc_q;
		nnote = note_q; noct = oct_q; nsemi = semi_q; done = 1'b0; m = '0;
		pos3 = chars_q[2:0];
		unique case (phase_q)
			PH_START: begin
				npm = '0;
				for (int k = 0; k < 4; k++)
					npm[k] = (c == hdr_char(2'(k), 3'd0));
				nacc = '0;
				if (c == 8'd124) nph = PH_BAR;
				else if (c == 8'd45) begin nph = PH_LEN0; nnote = NOTE_REST; end
				else if (c == 8'd75 || c == 8'd83 || c == 8'd72 || c == 8'd79) begin
					nph = PH_LEN0;
					nnote = (c == 8'd75) ? NOTE_K : (c == 8'd83) ? NOTE_S :
						(c == 8'd72) ? NOTE_H : NOTE_O;
				end else if (c >= 8'd65 && c <= 8'd71) begin
					nph = PH_OCT; nsemi = semitone_of(3'(c - 8'd65));
				end else if (npm != '0) nph = PH_PREFIX;
				else nph = PH_BAD;
			end
			PH_PREFIX: begin
				for (int k = 0; k < 4; k++) begin
					m[k] = pmatch_q[k] && ({1'b0, pos3} < hdr_len(2'(k))) &&
						(c == hdr_char(2'(k), pos3));
					done = done | (m[k] && ({1'b0, pos3} == hdr_len(2'(k)) - 4'd1));
					if (m[k] && ({1'b0, pos3} == hdr_len(2'(k)) - 4'd1)) nwh = 2'(k);
				end
				npm = m;
				if (done) nph = PH_HVAL;
				else if (m == '0) nph = PH_BAD;
			end
			PH_HVAL: begin
				if (is_dig) nacc = acc_digit(acc_q, c);
				else nph = PH_HBAD;
			end
			PH_BAR, PH_BAD, PH_HBAD: nph = (phase_q == PH_HBAD) ? PH_HBAD : PH_BAD;
			PH_LEN0: nph = (c == 8'd58) ? PH_LENNUM : PH_BAD;
			PH_LENNUM: begin
				if (is_dig) nacc = acc_digit(acc_q, c);
				else nph = PH_BAD;
			end
			PH_OCT, PH_OCTD: begin
				if (phase_q == PH_OCT && c == 8'd35) begin
					nph = PH_OCTD; nsemi = semi_q + 4'd1;
				end else if (c >= 8'd48 && c <= 8'd56) begin
					noct = c[3:0];
					nph = PH_LEN0;
					if (semi_q > 4'd11) begin nsemi = semi_q - 4'd12; noct = c[3:0] + 4'd1; end
				end else nph = PH_BAD;
			end
			default: nph = PH_BAD;
		endcase
	end

	// note code from letter/octave registers
	logic [7:0] pitch;
	assign pitch = 8'((oct_q + 4'd1) * 8'd12) + {4'd0, semi_q};

	// token completion
	logic        tok_any, emit, set_err, hdr_ok;
	logic [2:0]  terr;
	logic [7:0]  ev_note, ev_len;
	logic [4:0]  bar_next;
	logic        bar_clear;
	logic        is_note_tok;

	always_comb begin
		emit = 1'b0; set_err = 1'b0; terr = ST_OK; hdr_ok = 1'b0; bar_clear = 1'b0;
		ev_note = (note_q == 8'hFF) ? pitch : note_q;
		ev_len = 8'd1;
		is_note_tok = 1'b0;
		tok_any = (chars_q != 6'd0) && (err_q == ST_OK);
		if (tok_any) begin
			unique case (phase_q)
				PH_BAR: begin
					if (bar_q != BAR_STEPS) begin set_err = 1'b1; terr = ST_BAR; end
					else bar_clear = 1'b1;
				end
				PH_HVAL, PH_HBAD: begin
					if (ev_q != '0) begin set_err = 1'b1; terr = ST_HDR_LATE; end
					else if (phase_q == PH_HBAD || chars_q == {2'b00, hdr_len(which_q)}
						|| acc_q > 9'd255) begin set_err = 1'b1; terr = ST_BAD_VAL; end
					else if (which_q == HDR_DUTY && acc_q != 9'd12 && acc_q != 9'd25
						&& acc_q != 9'd50) begin set_err = 1'b1; terr = ST_UNKNOWN; end
					else hdr_ok = 1'b1;
				end
				PH_LEN0: is_note_tok = 1'b1;
				PH_LENNUM: begin
					if (acc_q == 9'd0 || acc_q > 9'd255) begin
						set_err = 1'b1; terr = ST_UNKNOWN;
					end else begin is_note_tok = 1'b1; ev_len = acc_q[7:0]; end
				end
				PH_PREFIX, PH_BAD, PH_OCT, PH_OCTD, PH_START: begin
					set_err = 1'b1; terr = ST_UNKNOWN;
				end
				default: begin set_err = 1'b1; terr = ST_UNKNOWN; end
			endcase
			if (is_note_tok) begin
				if ({{(32-EW){1'b0}}, ev_q} >= MAX_EVENTS) begin
					set_err = 1'b1; terr = ST_EVENTS;
				end else emit = 1'b1;
			end
		end
		bar_next = ({1'b0, bar_q} + {1'b0, ev_len[4:0]} > 6'd17 || ev_len[7:5] != 3'd0)
			? BAR_SAT : 5'(bar_q + ev_len[4:0]);
	end

	logic [16:0] sum_add;
	assign sum_add = {1'b0, sum_q} + {9'd0, ev_len};

	logic [15:0] sum_n;
	logic [4:0]  bar_n;
	logic [EW-1:0] ev_n;
	logic [2:0]  err_n;
	assign sum_n = emit ? (sum_add[16] ? 16'hFFFF : sum_add[15:0]) : sum_q;
	assign bar_n = emit ? bar_next : (bar_clear ? 5'd0 : bar_q);
	assign ev_n  = emit ? ev_q + EW'(1) : ev_q;
	assign err_n = set_err ? terr : err_q;

	logic [2:0] fin_err;
	assign fin_err = (err_n == ST_OK && bar_n != 5'd0 && bar_n != BAR_STEPS) ? ST_BAR : err_n;

	settings_t set_n;
	always_comb begin
		set_n = set_q;
		if (hdr_ok) begin
			unique case (which_q)
				HDR_DUTY:    set_n.duty    = acc_q[7:0];
				HDR_GAIN:    set_n.gain    = acc_q[7:0];
				HDR_DECAY:   set_n.decay   = acc_q[7:0];
				default:     set_n.sustain = acc_q[7:0];
			endcase
		end
	end

	result_t ev_r, fin_r;
	always_comb begin
		ev_r = '0;
		ev_r.note_code = ev_note;
		ev_r.step_len  = ev_len;
		fin_r = '0;
		fin_r.kind = 1'b1;
		fin_r.status = fin_err;
		fin_r.sets = set_n;
		fin_r.total_steps = sum_n;
		fin_r.event_count = 9'(ev_n);
	end

	logic chr_live, finish, keep;
	assign chr_live = acc_in && func == FUNC_CHAR && c != 8'd0 && err_q == ST_OK;
	assign finish   = (chr_live && is_sp) || (acc_in && func == FUNC_END);
	assign keep     = chr_live && !is_sp && ({26'd0, chars_q} < TOKEN_MAX);

	logic push0, push1;
	result_t d0, d1;
	assign push0 = (finish && emit) || (acc_in && func == FUNC_END);
	assign d0    = (finish && emit) ? ev_r : fin_r;
	assign push1 = acc_in && func == FUNC_END && emit;
	assign d1    = fin_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START; chars_q <= '0; pmatch_q <= '0; which_q <= '0;
			acc_q <= '0; note_q <= '0; oct_q <= '0; semi_q <= '0;
			bar_q <= '0; sum_q <= '0; ev_q <= '0; err_q <= ST_OK;
			set_q <= {DUTY_DEF, GAIN_DEF, DECAY_DEF, SUSTAIN_DEF};
		end else if (acc_in && func == FUNC_END) begin
			phase_q <= PH_START; chars_q <= '0; pmatch_q <= '0; which_q <= '0;
			acc_q <= '0; note_q <= '0; oct_q <= '0; semi_q <= '0;
			bar_q <= '0; sum_q <= '0; ev_q <= '0; err_q <= ST_OK;
			set_q <= {DUTY_DEF, GAIN_DEF, DECAY_DEF, SUSTAIN_DEF};
		end else if (finish) begin
			phase_q <= PH_START; chars_q <= '0;
			bar_q <= bar_n; sum_q <= sum_n; ev_q <= ev_n; err_q <= err_n;
			set_q <= set_n;
		end else if (keep) begin
			phase_q <= nph; chars_q <= chars_q + 6'd1; pmatch_q <= npm;
			which_q <= nwh; acc_q <= nacc; oct_q <= noct; semi_q <= nsemi;
			// pitched notes are marked with all-ones; their code comes from the octave and semitone
			note_q <= (phase_q == PH_START && c >= 8'd65 && c <= 8'd71) ? 8'hFF : nnote;
		end
	end

	nptp_out_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push0(push0), .din0(d0), .push1(push1), .din1(d1),
		.space2(space2), .valid(out_ch.valid), .dout(out_ch.data),
		.pop(out_ch.ready)
	);
endmodule
`default_nettype wire

// ===== rtl/nptp_checker.sv =====
// ----------------------------------------------------------------------------
// nptp_checker
// Port-level checks for the pattern token parser.
// ----------------------------------------------------------------------------
`default_nettype none
module nptp_checker
	import nptp_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    in_ready,
	input wire logic    out_valid,
	input wire logic    out_ready,
	input wire result_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_ev_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.kind |-> out_data.step_len != 8'd0 &&
		out_data.status == ST_OK)
		else $error("event with bad length or status");
	a_fin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind |-> out_data.note_code == 8'd0 &&
		out_data.step_len == 8'd0)
		else $error("final record carries note fields");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ST_UNKNOWN)
		else $error("status out of range");
	// an empty result queue always has room
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with no result pending");
endmodule

bind note_pattern_token_parser_core nptp_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks note_pattern_token_parser_core: pattern text goes in one byte per
// beat, each event and final record coming out is compared with a local model
// of the tokenizer. Directed patterns first, then random patterns and random bytes.
// ----------------------------------------------------------------------------
module testbench;
	import nptp_pkg::*;

	typedef struct packed {
		logic       func;
		logic [7:0] char_in;
	} char_beat_t;

	logic clk;
	logic arst_n;

	nptp_stream_if #(.payload_t(char_beat_t)) in_ch ();
	nptp_stream_if #(.payload_t(result_t))    out_ch ();

	note_pattern_token_parser_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	char_beat_t text_q[$];
	result_t    records_due[$];

	// parser model state
	logic [7:0]  tok[64];
	int          tok_n;
	int          bar_fill;
	int          total_sum;
	int          n_events;
	logic [2:0]  err_code;
	logic [7:0]  sets[4];

	int mismatches;
	int beats_in;
	int idle_left;
	int stall_left;
	int hold_left;
	bit hold_done;
	int quiet_cycles;

	task automatic clear_parser();
		tok_n = 0;
		bar_fill = 0;
		total_sum = 0;
		n_events = 0;
		err_code = ST_OK;
		sets[0] = DUTY_DEF;
		sets[1] = GAIN_DEF;
		sets[2] = DECAY_DEF;
		sets[3] = SUSTAIN_DEF;
	endtask

	function automatic bit tok_prefix(int n, string p);
		for (int i = 0; i < p.len(); i++)
			if (i >= n || tok[i] != p[i]) return 0;
		return 1;
	endfunction

	function automatic bit read_num(int pos, int n, output int v);
		int acc;
		acc = 0;
		v = 0;
		if (pos >= n) return 0;
		for (int i = pos; i < n; i++) begin
			if (tok[i] < "0" || tok[i] > "9") return 0;
			acc = acc * 10 + (tok[i] - "0");
			if (acc > 256) acc = 256;
		end
		v = acc;
		return 1;
	endfunction

	function automatic bit read_len(int pos, int n, output int len);
		int v;
		len = 1;
		if (pos >= n) return 1;
		if (tok[pos] != ":") return 0;
		if (!read_num(pos + 1, n, v)) return 0;
		if (v < 1 || v > 255) return 0;
		len = v;
		return 1;
	endfunction

	task automatic emit_event(logic [7:0] code, int len);
		result_t r;
		if (n_events >= MAX_EVENTS_DEF) begin
			err_code = ST_EVENTS;
			return;
		end
		n_events++;
		total_sum += len;
		if (total_sum > 65535) total_sum = 65535;
		bar_fill += len;
		if (bar_fill > 17) bar_fill = 17;
		r = '0;
		r.note_code = code;
		r.step_len = len[7:0];
		records_due.push_back(r);
	endtask

	task automatic close_token();
		int n, len, v, which, semi, oct, i;
		logic [7:0] c0, c1, d;
		logic [7:0] code;
		n = tok_n;
		tok_n = 0;
		if (n == 0 || err_code != ST_OK) return;
		c0 = tok[0];
		c1 = (n > 1) ? tok[1] : 8'd0;
		if (c0 == "|" && n == 1) begin
			if (bar_fill != BAR_STEPS) err_code = ST_BAR;
			else bar_fill = 0;
			return;
		end
		which = 4;
		if (tok_prefix(n, "duty=")) which = HDR_DUTY;
		else if (tok_prefix(n, "gain=")) which = HDR_GAIN;
		else if (tok_prefix(n, "decay=")) which = HDR_DECAY;
		else if (tok_prefix(n, "sustain=")) which = HDR_SUSTAIN;
		if (which < 4) begin
			if (n_events != 0) begin
				err_code = ST_HDR_LATE;
				return;
			end
			i = (which == HDR_DECAY) ? 6 : (which == HDR_SUSTAIN) ? 8 : 5;
			if (!read_num(i, n, v) || v > 255) begin
				err_code = ST_BAD_VAL;
				return;
			end
			if (which == HDR_DUTY && v != 12 && v != 25 && v != 50) begin
				err_code = ST_UNKNOWN;
				return;
			end
			sets[which] = v[7:0];
			return;
		end
		if (c0 == "-") begin
			if (!read_len(1, n, len)) err_code = ST_UNKNOWN;
			else emit_event(NOTE_REST, len);
			return;
		end
		if ((c0 == "K" || c0 == "S" || c0 == "H" || c0 == "O") && (n == 1 || c1 == ":")) begin
			code = (c0 == "S") ? NOTE_S : (c0 == "H") ? NOTE_H : (c0 == "O") ? NOTE_O : NOTE_K;
			if (!read_len(1, n, len)) err_code = ST_UNKNOWN;
			else emit_event(code, len);
			return;
		end
		if (c0 >= "A" && c0 <= "G") begin
			case (c0)
				"A": semi = 9;
				"B": semi = 11;
				"C": semi = 0;
				"D": semi = 2;
				"E": semi = 4;
				"F": semi = 5;
				default: semi = 7;
			endcase
			i = 1;
			if (i < n && tok[i] == "#") begin
				semi++;
				i++;
			end
			d = (i < n) ? tok[i] : 8'd0;
			if (d < "0" || d > "8") begin
				err_code = ST_UNKNOWN;
				return;
			end
			oct = d - "0";
			i++;
			// B# wraps into the next octave
			if (semi > 11) begin
				semi -= 12;
				oct++;
			end
			if (!read_len(i, n, len)) err_code = ST_UNKNOWN;
			else emit_event(8'(12 * (oct + 1) + semi), len);
			return;
		end
		err_code = ST_UNKNOWN;
	endtask

	task automatic parse_beat(char_beat_t b);
		result_t r;
		if (b.func == FUNC_CHAR) begin
			if (b.char_in == 0 || err_code != ST_OK) return;
			if (b.char_in == " " || b.char_in == 8'd9 || b.char_in == 8'd10 ||
			    b.char_in == 8'd13) begin
				close_token();
			end else if (tok_n < TOKEN_MAX_DEF) begin
				tok[tok_n] = b.char_in;
				tok_n++;
			end
			return;
		end
		close_token();
		if (err_code == ST_OK && bar_fill != 0 && bar_fill != BAR_STEPS) err_code = ST_BAR;
		r = '0;
		r.kind = 1'b1;
		r.status = err_code;
		r.sets = {sets[0], sets[1], sets[2], sets[3]};
		r.total_steps = total_sum[15:0];
		r.event_count = n_events[8:0];
		records_due.push_back(r);
		clear_parser();
	endtask

	// ---------------- stimulus helpers ----------------
	task automatic put_byte(logic [7:0] c);
		char_beat_t b;
		b.func = FUNC_CHAR;
		b.char_in = c;
		text_q.push_back(b);
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++) put_byte(s[i]);
	endtask

	task automatic put_end();
		char_beat_t b;
		b.func = FUNC_END;
		b.char_in = 8'($urandom_range(0, 255));
		text_q.push_back(b);
	endtask

	function automatic string gap_text();
		case ($urandom_range(0, 7))
			0: return "\t";
			1: return "\n";
			2: return "\r\n";
			3: return "  ";
			default: return " ";
		endcase
	endfunction

	function automatic string rand_token(int len);
		string s, l;
		int k;
		case ($urandom_range(0, 3))
			0: s = "-";
			1: begin
				l = "KSHO";
				k = $urandom_range(0, 3);
				s = l.substr(k, k);
			end
			default: begin
				l = "ABCDEFG";
				k = $urandom_range(0, 6);
				s = l.substr(k, k);
				if ($urandom_range(0, 2) == 0) s = {s, "#"};
				s = {s, $sformatf("%0d", $urandom_range(0, 8))};
			end
		endcase
		if (len != 1 || $urandom_range(0, 3) == 0) s = {s, $sformatf(":%0d", len)};
		return s;
	endfunction

	task automatic put_rand_pattern();
		int bars, left, len;
		string hdr[4];
		int vals[3];
		hdr = '{"duty=", "gain=", "decay=", "sustain="};
		vals = '{12, 25, 50};
		for (int h = 0; h < 4; h++)
			if ($urandom_range(0, 2) == 0) begin
				put_text(hdr[h]);
				if (h == 0) put_text($sformatf("%0d", vals[$urandom_range(0, 2)]));
				else put_text($sformatf("%0d", $urandom_range(0, 255)));
				put_text(gap_text());
			end
		bars = $urandom_range(0, 4);
		for (int b = 0; b < bars; b++) begin
			left = 16;
			while (left > 0) begin
				len = ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(1, left);
				left -= len;
				put_text(rand_token(len));
				put_text(gap_text());
				// occasional corruption
				if ($urandom_range(0, 40) == 0) put_byte(8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 3) != 0) begin
				put_text("|");
				put_text(gap_text());
			end
		end
		if ($urandom_range(0, 5) == 0) put_text(rand_token($urandom_range(1, 255)));
		put_end();
	endtask

	initial begin
		clear_parser();
		put_text("duty=12 gain=0 decay=255\tsustain=7\nC0 B#8:255 A8 - -:1 K S:3 H O:16 |");
		put_end();
		put_text("duty=25 D#4:4 E4:4 F4:4 G4:4 | ");
		put_end();
		put_text("duty=13 C4");
		put_end();
		put_text("gain=256 ");
		put_end();
		put_text("gain= ");
		put_end();
		put_text("C4 decay=3 ");
		put_end();
		put_text("X K:0 C9 ");
		put_end();
		put_text("C");
		put_byte(8'd0);
		put_text("4:16 |");
		put_end();
		put_text("sustain=");
		for (int i = 0; i < 70; i++) put_text("9");
		put_end();
		// event limit: one more drum than allowed
		for (int i = 0; i <= MAX_EVENTS_DEF; i++) put_text("K ");
		put_end();
		while (text_q.size() < 1560) put_rand_pattern();
		// random bytes so that every bit of the character toggles
		for (int i = 0; i < 40; i++) put_byte(8'($urandom_range(0, 255)));
		put_end();
	end

	// ---------------- clock and reset ----------------
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
	end

	// ---------------- driver ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			idle_left = 0;
			beats_in = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				parse_beat(in_ch.data);
				beats_in++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (idle_left > 0) begin
					idle_left--;
					in_ch.valid <= 1'b0;
				end else if (text_q.size() > 0) begin
					in_ch.data <= text_q.pop_front();
					in_ch.valid <= 1'b1;
					if (text_q.size() > 300 && $urandom_range(0, 9) == 0)
						idle_left = $urandom_range(1, 11);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			mismatches = 0;
			stall_left = 0;
			hold_left = 0;
			hold_done = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (records_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat: kind=%0d note=%0d len=%0d",
							got.kind, got.note_code, got.step_len);
				end else begin
					want = records_due.pop_front();
					if (got.kind !== want.kind || got.note_code !== want.note_code ||
					    got.step_len !== want.step_len || got.status !== want.status ||
					    got.sets !== want.sets || got.total_steps !== want.total_steps ||
					    got.event_count !== want.event_count) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp kind=%0d note=%0d len=%0d st=%0d ",
								"sets=%h steps=%0d ev=%0d / got %0d %0d %0d %0d %h %0d %0d"},
								want.kind, want.note_code, want.step_len, want.status,
								want.sets, want.total_steps, want.event_count,
								got.kind, got.note_code, got.step_len, got.status,
								got.sets, got.total_steps, got.event_count);
					end
				end
			end
			// one long hold-off so the input backs up
			if (!hold_done && beats_in >= 400) begin
				hold_done = 1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if (text_q.size() > 300 && $urandom_range(0, 9) == 0)
					stall_left = $urandom_range(1, 11);
			end
		end
	end

	// ---------------- watchdog ----------------
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 2000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		quiet_cycles = 0;
		@(posedge arst_n);
		wait (text_q.size() == 0 && !in_ch.valid && records_due.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && records_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
